### design/pes_pkg.sv
`default_nettype none

package pes_pkg;

	localparam logic [2:0] RESET_STEPS = 3'd6;
	localparam logic [2:0] HOLD_STEPS_MAX = 3'd7;

	localparam logic [15:0] START_PRESS_RST = 16'd10000;
	localparam logic [7:0] MAX_ERROR_RST = 8'd100;
	localparam logic [15:0] FINGER_TMO_RST = 16'd1000;
	localparam logic [15:0] RESPONSE_TMO_RST = 16'd1200;
	localparam logic [15:0] RESET_STEP_RST = 16'd500;

	localparam logic [7:0] ERROR_SAT = 8'hFF;
	localparam logic [15:0] ELAPSED_SAT = 16'hFFFF;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_START_PRESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FINGER_TMO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_TMO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_STEP = 3'd4;

	localparam logic [2:0] CODE_CONFIG = 3'd0;
	localparam logic [2:0] CODE_PRESS = 3'd1;
	localparam logic [2:0] CODE_WAIT = 3'd2;
	localparam logic [2:0] CODE_PAUSE = 3'd3;
	localparam logic [2:0] CODE_FINISH = 3'd4;
	localparam logic [2:0] CODE_FAILURE = 3'd5;

	typedef enum logic [5:0] {
		M_CONFIG  = 6'b000001,
		M_PRESS   = 6'b000010,
		M_WAIT    = 6'b000100,
		M_PAUSE   = 6'b001000,
		M_FINISH  = 6'b010000,
		M_FAILURE = 6'b100000
	} mode_t;

	typedef struct packed {
		logic finger_down;
		logic contact_made;
		logic key_click;
		logic key_held;
		logic key_released_long;
	} tick_in_t;

	typedef struct packed {
		logic [2:0]  mode_code;
		logic        finger_drive;
		logic        indicator_led;
		logic [15:0] presses_left;
		logic [7:0]  errors_seen;
		logic        press_error;
		logic [15:0] failed_press_number;
		logic        finger_fault;
		logic [2:0]  reset_progress;
	} tick_out_t;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			M_PRESS:   c = CODE_PRESS;
			M_WAIT:    c = CODE_WAIT;
			M_PAUSE:   c = CODE_PAUSE;
			M_FINISH:  c = CODE_FINISH;
			M_FAILURE: c = CODE_FAILURE;
			default:   c = CODE_CONFIG;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### design/press_endurance_sequencer.sv
`default_nettype none

// channel   | dir | handshake             | payload
// ----------+-----+-----------------------+------------------------------
// in        | in  | in_valid / in_stall   | in_data  (tick_in_t)
// out       | out | out_valid / out_stall | out_data (tick_out_t)
// cfg       | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One tick per cycle while in_stall is low: the whole update is one pass of
// logic from the state registers and the request into the output register.
// A skid register behind the output keeps one extra result; in_stall rises
// only while it is full. arst_n selects config mode, reloads the press count,
// clears errors, timer and handshakes, and loads the config register defaults.
// cfg_ready is always high.
module press_endurance_sequencer (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire pes_pkg::tick_in_t            in_data,
	output logic                              out_valid,
	input  wire                               out_stall,
	output pes_pkg::tick_out_t                out_data,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [pes_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [pes_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pes_pkg::*;

	logic [15:0] start_press_q;
	logic [7:0]  max_error_q;
	logic [15:0] finger_tmo_q;
	logic [15:0] response_tmo_q;
	logic [15:0] reset_step_q;

	mode_t       mode_q, mode_n;
	logic [15:0] presses_q, presses_n;
	logic [7:0]  errors_q, errors_n;
	logic [15:0] elapsed_q, elapsed_n;
	logic [2:0]  hold_q, hold_n;
	logic        latched_q, latched_n;
	logic        finger_q, finger_n;
	logic        led_q, led_n;
	logic        perr, ffault;
	logic [15:0] failed_no;

	tick_out_t   result;
	tick_out_t   out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        accept, taken;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign accept    = in_valid && !skid_valid_q;
	assign taken     = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_press_q  <= START_PRESS_RST;
			max_error_q    <= MAX_ERROR_RST;
			finger_tmo_q   <= FINGER_TMO_RST;
			response_tmo_q <= RESPONSE_TMO_RST;
			reset_step_q   <= RESET_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_PRESS:  start_press_q  <= cfg_data;
				REG_MAX_ERROR:    max_error_q    <= cfg_data[7:0];
				REG_FINGER_TMO:   finger_tmo_q   <= cfg_data;
				REG_RESPONSE_TMO: response_tmo_q <= cfg_data;
				REG_RESET_STEP:   reset_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		mode_n    = mode_q;
		presses_n = presses_q;
		errors_n  = errors_q;
		elapsed_n = elapsed_q;
		hold_n    = hold_q;
		latched_n = latched_q;
		finger_n  = finger_q;
		led_n     = led_q;
		perr      = 1'b0;
		ffault    = 1'b0;
		failed_no = '0;

		if (mode_n == M_PRESS) begin
			if (presses_n != '0) begin
				finger_n  = 1'b1;
				mode_n    = M_WAIT;
				elapsed_n = '0;
			end else begin
				mode_n = M_FINISH;
			end
		end

		if (mode_n == M_WAIT) begin
			if (!in_data.finger_down) begin
				if (elapsed_n > finger_tmo_q) begin
					ffault = 1'b1;
					mode_n = M_CONFIG;
				end
			end else if (!in_data.contact_made) begin
				led_n = 1'b1;
				if (elapsed_n > response_tmo_q) begin
					led_n     = 1'b0;
					perr      = 1'b1;
					failed_no = presses_n;
					if (errors_n != ERROR_SAT)
						errors_n = errors_n + 8'd1;
					mode_n = (errors_n > max_error_q) ? M_FAILURE : M_PRESS;
				end
			end else begin
				led_n     = 1'b0;
				presses_n = presses_n - 16'd1;
				finger_n  = 1'b0;
				mode_n    = M_PRESS;
			end
		end

		if (mode_n != M_CONFIG) begin
			if (in_data.key_click && mode_n != M_FAILURE)
				mode_n = (mode_n == M_PAUSE) ? M_PRESS : M_PAUSE;
		end else if (in_data.key_click) begin
			mode_n = M_PRESS;
		end

		// long hold: first tick pauses, then one step per reset_step timeout
		if (in_data.key_held && !latched_n) begin
			if (hold_n == '0) begin
				mode_n    = M_PAUSE;
				elapsed_n = '0;
				hold_n    = 3'd1;
			end
			if (elapsed_n > reset_step_q) begin
				if (hold_n != HOLD_STEPS_MAX)
					hold_n = hold_n + 3'd1;
				elapsed_n = '0;
			end
			if (hold_n == RESET_STEPS) begin
				mode_n    = M_CONFIG;
				presses_n = start_press_q;
				errors_n  = '0;
				latched_n = 1'b1;
			end
		end else if (in_data.key_released_long) begin
			hold_n = '0;
			if (latched_n)
				latched_n = 1'b0;
			else
				mode_n = (errors_n > max_error_q) ? M_FAILURE : M_PAUSE;
		end

		if (mode_n != M_PRESS && mode_n != M_WAIT) begin
			finger_n = 1'b0;
			led_n    = 1'b0;
		end

		if (elapsed_n != ELAPSED_SAT)
			elapsed_n = elapsed_n + 16'd1;

		result.mode_code           = mode_code(mode_n);
		result.finger_drive        = finger_n;
		result.indicator_led       = led_n;
		result.presses_left        = presses_n;
		result.errors_seen         = errors_n;
		result.press_error         = perr;
		result.failed_press_number = failed_no;
		result.finger_fault        = ffault;
		result.reset_progress      = hold_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_CONFIG;
			presses_q <= START_PRESS_RST;
			errors_q  <= '0;
			elapsed_q <= '0;
			hold_q    <= '0;
			latched_q <= 1'b0;
			finger_q  <= 1'b0;
			led_q     <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_n;
			presses_q <= presses_n;
			errors_q  <= errors_n;
			elapsed_q <= elapsed_n;
			hold_q    <= hold_n;
			latched_q <= latched_n;
			finger_q  <= finger_n;
			led_q     <= led_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (taken) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || taken)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (taken) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (taken)
				out_q <= skid_q;
		end else if (accept) begin
			if (!out_valid_q || taken)
				out_q <= result;
			else
				skid_q <= result;
		end
	end

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

import pes_pkg::*;

class tick_scoreboard;
	tick_out_t expected_ticks[$];
	int mismatches;

	logic [15:0] start_count;
	logic [7:0]  error_limit;
	logic [15:0] finger_tmo;
	logic [15:0] contact_tmo;
	logic [15:0] step_ms;

	logic [2:0]  mode;
	logic [15:0] presses;
	logic [7:0]  error_total;
	logic [15:0] elapsed;
	logic [2:0]  hold_steps;
	logic        latched;
	logic        finger_on;
	logic        led_on;

	function new();
		mismatches = 0;
		start_count = START_PRESS_RST;
		error_limit = MAX_ERROR_RST;
		finger_tmo = FINGER_TMO_RST;
		contact_tmo = RESPONSE_TMO_RST;
		step_ms = RESET_STEP_RST;
		mode = CODE_CONFIG;
		presses = START_PRESS_RST;
		error_total = '0;
		elapsed = '0;
		hold_steps = '0;
		latched = 1'b0;
		finger_on = 1'b0;
		led_on = 1'b0;
	endfunction

	function void note_config(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		unique case (idx)
			REG_START_PRESS:  start_count = data;
			REG_MAX_ERROR:    error_limit = data[7:0];
			REG_FINGER_TMO:   finger_tmo = data;
			REG_RESPONSE_TMO: contact_tmo = data;
			REG_RESET_STEP:   step_ms = data;
			default: ;
		endcase
	endfunction

	function tick_out_t tick_update(tick_in_t t);
		tick_out_t r;
		logic        missed;
		logic        fault;
		logic [15:0] missed_at;
		missed = 1'b0;
		fault = 1'b0;
		missed_at = '0;
		if (mode > CODE_FAILURE) begin
			mode = CODE_CONFIG;
		end
		if (mode == CODE_PRESS) begin
			if (presses != 0) begin
				finger_on = 1'b1;
				mode = CODE_WAIT;
				elapsed = '0;
			end else begin
				mode = CODE_FINISH;
			end
		end
		if (mode == CODE_WAIT) begin
			if (!t.finger_down) begin
				if (elapsed > finger_tmo) begin
					fault = 1'b1;
					mode = CODE_CONFIG;
				end
			end else if (!t.contact_made) begin
				led_on = 1'b1;
				if (elapsed > contact_tmo) begin
					led_on = 1'b0;
					missed = 1'b1;
					missed_at = presses;
					if (error_total < ERROR_SAT) begin
						error_total = error_total + 1'b1;
					end
					mode = (error_total > error_limit) ? CODE_FAILURE : CODE_PRESS;
				end
			end else begin
				led_on = 1'b0;
				presses = presses - 1'b1;
				finger_on = 1'b0;
				mode = CODE_PRESS;
			end
		end
		if (mode != CODE_CONFIG) begin
			if (t.key_click && mode != CODE_FAILURE) begin
				mode = (mode == CODE_PAUSE) ? CODE_PRESS : CODE_PAUSE;
			end
		end else if (t.key_click) begin
			mode = CODE_PRESS;
		end
		if (t.key_held && !latched) begin
			if (hold_steps == 0) begin
				mode = CODE_PAUSE;
				elapsed = '0;
				hold_steps = 3'd1;
			end
			if (elapsed > step_ms) begin
				if (hold_steps < HOLD_STEPS_MAX) begin
					hold_steps = hold_steps + 1'b1;
				end
				elapsed = '0;
			end
			if (hold_steps == RESET_STEPS) begin
				mode = CODE_CONFIG;
				presses = start_count;
				error_total = '0;
				latched = 1'b1;
			end
		end else if (t.key_released_long) begin
			hold_steps = '0;
			if (latched) begin
				latched = 1'b0;
			end else begin
				mode = (error_total > error_limit) ? CODE_FAILURE : CODE_PAUSE;
			end
		end
		if (mode != CODE_PRESS && mode != CODE_WAIT) begin
			finger_on = 1'b0;
			led_on = 1'b0;
		end
		if (elapsed < ELAPSED_SAT) begin
			elapsed = elapsed + 1'b1;
		end
		r.mode_code = mode;
		r.finger_drive = finger_on;
		r.indicator_led = led_on;
		r.presses_left = presses;
		r.errors_seen = error_total;
		r.press_error = missed;
		r.failed_press_number = missed_at;
		r.finger_fault = fault;
		r.reset_progress = hold_steps;
		return r;
	endfunction

	function void note_request(tick_in_t t);
		expected_ticks.push_back(tick_update(t));
	endfunction

	function string show(tick_out_t v);
		return $sformatf({"mode=%0d drive=%0b led=%0b left=%0d err=%0d",
			" miss=%0b at=%0d fault=%0b steps=%0d"},
			v.mode_code, v.finger_drive, v.indicator_led, v.presses_left, v.errors_seen,
			v.press_error, v.failed_press_number, v.finger_fault, v.reset_progress);
	endfunction

	function void check_result(tick_out_t got);
		tick_out_t want;
		string diff;
		if (expected_ticks.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result with no request pending: %s", show(got));
			end
			return;
		end
		want = expected_ticks.pop_front();
		diff = "";
		if (got.mode_code !== want.mode_code) diff = {diff, " mode_code"};
		if (got.finger_drive !== want.finger_drive) diff = {diff, " finger_drive"};
		if (got.indicator_led !== want.indicator_led) diff = {diff, " indicator_led"};
		if (got.presses_left !== want.presses_left) diff = {diff, " presses_left"};
		if (got.errors_seen !== want.errors_seen) diff = {diff, " errors_seen"};
		if (got.press_error !== want.press_error) diff = {diff, " press_error"};
		if (got.failed_press_number !== want.failed_press_number) begin
			diff = {diff, " failed_press_number"};
		end
		if (got.finger_fault !== want.finger_fault) diff = {diff, " finger_fault"};
		if (got.reset_progress !== want.reset_progress) diff = {diff, " reset_progress"};
		if (diff != "") begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch:%s\n  expected %s\n  actual   %s",
					diff, show(want), show(got));
			end
		end
	endfunction

	function int pending();
		return expected_ticks.size();
	endfunction
endclass

module tb;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 203;
	localparam int PHASES = 8;
	localparam int FIRST_SPARE_REG = 5;
	localparam int LAST_SPARE_REG = (1 << CFG_IDX_W) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tick_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tick_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tick_scoreboard board = new();
	int cycles = 0;
	bit tx_gaps = 1'b0;
	bit rx_stalls = 1'b0;
	int hold_off_asks = 0;
	int hold_off_done = 0;
	int stall_left = 0;

	// operator key and sensor shaping for the random part
	int hold_left = 0;
	bit release_due = 1'b0;
	int p_fdown = 90;
	int p_contact = 30;

	press_endurance_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			board.check_result(out_data);
		end
	end

	function automatic int burst_len();
		if ($urandom_range(99) < 10) begin
			return $urandom_range(10, 30);
		end
		return $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		if (hold_off_asks != hold_off_done) begin
			// long hold-off so the skid fills and the block pushes back on requests
			hold_off_done <= hold_off_asks;
			stall_left <= 63;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (rx_stalls && $urandom_range(99) < 25) begin
			stall_left <= burst_len() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic tick_in_t make_tick(bit fd, bit ct, bit ck, bit hd, bit rl);
		return tick_in_t'({fd, ct, ck, hd, rl});
	endfunction

	function automatic tick_in_t next_tick();
		tick_in_t t;
		int click_pct;
		int hold_pct;
		t = '0;
		if ($urandom_range(29) == 0) begin
			case ($urandom_range(3))
				0: p_fdown = 100;
				1: p_fdown = 95;
				2: p_fdown = 60;
				default: p_fdown = 20;
			endcase
			case ($urandom_range(3))
				0: p_contact = 70;
				1: p_contact = 30;
				2: p_contact = 8;
				default: p_contact = 0;
			endcase
		end
		if ($urandom_range(99) < 4) begin
			return tick_in_t'(5'($urandom));
		end
		t.finger_down = $urandom_range(99) < p_fdown;
		t.contact_made = $urandom_range(99) < (t.finger_down ? p_contact : 10);
		if (hold_left != 0) begin
			hold_left--;
			t.key_held = 1'b1;
			if (hold_left == 0) release_due = $urandom_range(9) != 0;
			return t;
		end
		if (release_due) begin
			release_due = 1'b0;
			t.key_released_long = 1'b1;
			return t;
		end
		case (board.mode) inside
			CODE_CONFIG: begin
				click_pct = 25;
				hold_pct = 3;
			end
			CODE_PRESS, CODE_WAIT: begin
				click_pct = 2;
				hold_pct = 1;
			end
			CODE_PAUSE: begin
				click_pct = 20;
				hold_pct = 4;
			end
			default: begin
				click_pct = 10;
				hold_pct = 15;
			end
		endcase
		if ($urandom_range(99) < hold_pct) begin
			hold_left = ($urandom_range(3) == 0) ? $urandom_range(0, 3) : $urandom_range(8, 40);
			t.key_held = 1'b1;
			if (hold_left == 0) release_due = 1'b1;
			return t;
		end
		t.key_click = $urandom_range(99) < click_pct;
		return t;
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.note_config(idx, data);
	endtask

	task automatic set_config(input logic [15:0] starts, input logic [7:0] limit,
			input logic [15:0] ftmo, input logic [15:0] rtmo, input logic [15:0] step);
		logic [CFG_IDX_W-1:0] spare_idx;
		spare_idx = CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG));
		cfg_write(REG_START_PRESS, starts);
		// upper byte is dropped by the block
		cfg_write(REG_MAX_ERROR, {8'($urandom), limit});
		cfg_write(REG_FINGER_TMO, ftmo);
		cfg_write(REG_RESPONSE_TMO, rtmo);
		cfg_write(REG_RESET_STEP, step);
		cfg_write(spare_idx, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic offer(input tick_in_t t);
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(t);
		if (tx_gaps && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat (burst_len()) @(posedge clk);
		end
	endtask

	task automatic close_requests();
		in_valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		int phase;
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_gaps = 1'b1;
		rx_stalls <= 1'b1;

		// reset register values, then a click and hold together, then a release
		offer(make_tick(0, 0, 0, 0, 0));
		offer(make_tick(1, 1, 1, 1, 1));
		offer(make_tick(0, 0, 0, 0, 1));
		close_requests();

		set_config(16'd3, 8'd1, 16'd2, 16'd2, 16'd1);
		offer(make_tick(0, 0, 1, 0, 0));
		offer(make_tick(1, 1, 0, 0, 0));
		// two missed presses, the second one over the error limit
		repeat (8) offer(make_tick(1, 0, 0, 0, 0));
		offer(make_tick(0, 0, 1, 0, 0));
		offer(make_tick(0, 0, 0, 0, 1));
		offer(make_tick(1, 1, 1, 1, 1));
		offer(make_tick(0, 0, 1, 0, 0));
		// finger never reaches position
		repeat (4) offer(make_tick(0, 0, 0, 0, 0));
		offer(make_tick(0, 0, 1, 0, 0));
		offer(make_tick(0, 1, 0, 0, 0));
		offer(make_tick(0, 0, 0, 0, 1));
		close_requests();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_config(16'd5, 8'd3, 16'd3, 16'd4, 16'd2);
				1: set_config(16'd0, 8'd0, 16'd1, 16'd1, 16'd1);
				2: set_config(16'hFFFF, 8'd254, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				default: set_config(16'($urandom_range(1, 12)), 8'($urandom_range(0, 5)),
					16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
					16'($urandom_range(1, 4)));
			endcase
			tx_gaps = (phase != 0 && phase != 3) && ($urandom_range(3) != 0);
			rx_stalls <= (phase != 0) && ($urandom_range(3) != 0);
			if (phase == 3) begin
				hold_off_asks <= hold_off_asks + 1;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 3 && n == PHASE_ITEMS / 2) begin
					close_requests();
					tx_gaps = 1'b1;
				end
				offer(next_tick());
			end
			close_requests();
		end

		repeat (4) @(posedge clk);
		if (board.pending() != 0) begin
			board.mismatches++;
		end
		if (board.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

### sim.f
design/pes_pkg.sv
design/press_endurance_sequencer.sv
test/tb.sv
